/* design/itc_pkg.sv */
package itc_pkg;

	localparam int CELLS   = 11;
	localparam int DIGIT_W = 4;
	localparam int POS_W   = 4;
	localparam int BASE_W  = 5;
	localparam int CHAR_W  = 7;
	localparam int NUM_W   = 32;
	localparam int CNT_W   = 5;
	localparam int SEL_W   = 2;

	localparam logic [SEL_W-1:0] RADIX_OCT = 2'd0;
	localparam logic [SEL_W-1:0] RADIX_DEC = 2'd1;
	localparam logic [SEL_W-1:0] RADIX_HEX = 2'd2;

	localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2d;

	localparam logic [CNT_W-1:0] LAST_BIT = 5'd31;

	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SCAN,
		S_SIGN,
		S_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

/* design/integer_to_ascii_radix.sv */
// Converts a 32-bit value to ASCII text in octal, decimal (signed) or lower-case hex,
// one character per output beat, most significant digit first, tlast on the final
// character. The magnitude is shifted in one bit per cycle, MSB first, through a row
// of eleven radix cells that double their digit and pass a carry to the next cell,
// so every item passes through the idle state that takes it, the conversion of all 32
// bits, a scan that finds the leading digit and then one output beat per character,
// including a leading minus (1 to 11 characters). A new item is taken once the last
// character is in the output register.
module integer_to_ascii_radix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // number_in
	input  logic [1:0]  s_tuser,   // radix_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // char_out, zero pad
	output logic        m_tlast    // is_last
);

	itc_pkg::state_t state_q, state_d;

	logic [itc_pkg::NUM_W-1:0]   mag_q;
	logic [itc_pkg::BASE_W-1:0]  base_q;
	logic                        neg_q;
	logic [itc_pkg::CNT_W-1:0]   cnt_q;
	logic [itc_pkg::POS_W-1:0]   pos_q;
	logic                        m_tvalid_q;
	logic [itc_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	logic                        accept;
	logic                        shift_en;
	logic                        out_free;
	logic                        load_sign;
	logic                        load_digit;
	logic [itc_pkg::BASE_W-1:0]  base_in;
	logic                        neg_in;
	logic [itc_pkg::POS_W-1:0]   top_idx;

	logic [itc_pkg::DIGIT_W-1:0] digits [itc_pkg::CELLS];
	logic [itc_pkg::CELLS:0]     carry;

	// radix cells, cell 0 holds the least significant digit
	assign carry[0] = mag_q[itc_pkg::NUM_W-1];

	for (genvar i = 0; i < itc_pkg::CELLS; i++) begin : g_cell
		itc_cell u_cell (
			.clk   (clk),
			.clear (accept),
			.shift (shift_en),
			.base  (base_q),
			.cin   (carry[i]),
			.cout  (carry[i+1]),
			.digit (digits[i])
		);
	end

	always_comb begin
		if (s_tuser[1]) begin
			base_in = itc_pkg::BASE_HEX;
		end else if (s_tuser[0]) begin
			base_in = itc_pkg::BASE_DEC;
		end else begin
			base_in = itc_pkg::BASE_OCT;
		end
	end

	assign neg_in = (s_tuser == itc_pkg::RADIX_DEC) && s_tdata[itc_pkg::NUM_W-1];

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < itc_pkg::CELLS; i++) begin
			if (digits[i] != '0) begin
				top_idx = itc_pkg::POS_W'(i);
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itc_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = itc_pkg::S_CONV;
				end
			end
			itc_pkg::S_CONV: begin
				if (cnt_q == itc_pkg::LAST_BIT) begin
					state_d = itc_pkg::S_SCAN;
				end
			end
			itc_pkg::S_SCAN: begin
				state_d = neg_q ? itc_pkg::S_SIGN : itc_pkg::S_EMIT;
			end
			itc_pkg::S_SIGN: begin
				if (out_free) begin
					state_d = itc_pkg::S_EMIT;
				end
			end
			itc_pkg::S_EMIT: begin
				if (out_free && pos_q == '0) begin
					state_d = itc_pkg::S_IDLE;
				end
			end
			default: state_d = itc_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		shift_en   = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		unique case (state_q)
			itc_pkg::S_IDLE: s_tready   = 1'b1;
			itc_pkg::S_CONV: shift_en   = 1'b1;
			itc_pkg::S_SCAN: ;
			itc_pkg::S_SIGN: load_sign  = out_free;
			itc_pkg::S_EMIT: load_digit = out_free;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= itc_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
			pos_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load_sign || load_digit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (shift_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == itc_pkg::S_SCAN) begin
				pos_q <= top_idx;
			end else if (load_digit && pos_q != '0) begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= neg_in ? (~s_tdata + 1'b1) : s_tdata;
			base_q <= base_in;
			neg_q  <= neg_in;
		end else if (shift_en) begin
			mag_q <= {mag_q[itc_pkg::NUM_W-2:0], 1'b0};
		end
		if (load_sign) begin
			char_q <= itc_pkg::MINUS_CHAR;
			last_q <= 1'b0;
		end else if (load_digit) begin
			char_q <= itc_pkg::digit_char(digits[pos_q]);
			last_q <= (pos_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	// the top cell never carries out, eleven digits cover every radix
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |-> !carry[itc_pkg::CELLS])
		else $error("radix cell row overflow");

	// a digit being emitted is below the radix
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_digit |-> ({1'b0, digits[pos_q]} < base_q))
		else $error("digit out of range for radix");

	// last character ends the item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_digit && pos_q == '0) |=> (state_q == itc_pkg::S_IDLE && m_tvalid && m_tlast))
		else $error("last character did not end the item");

	// a new output beat only comes from the sign or digit phase
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == itc_pkg::S_SIGN
			|| $past(state_q) == itc_pkg::S_EMIT))
		else $error("output beat without a character load");

endmodule

/* design/itc_cell.sv */
module itc_cell (
	input  logic                           clk,
	input  logic                           clear,
	input  logic                           shift,
	input  logic [itc_pkg::BASE_W-1:0]     base,
	input  logic                           cin,
	output logic                           cout,
	output logic [itc_pkg::DIGIT_W-1:0]    digit
);

	logic [itc_pkg::DIGIT_W-1:0] digit_q;
	logic [itc_pkg::BASE_W-1:0]  doubled;
	logic [itc_pkg::BASE_W-1:0]  reduced;

	// 2d + cin reaches the base exactly when d reaches half the base
	assign cout    = {1'b0, digit_q} >= (base >> 1);
	assign doubled = {digit_q, cin};
	assign reduced = doubled - (cout ? base : '0);
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= reduced[itc_pkg::DIGIT_W-1:0];
		end
	end

endmodule

/* test/integer_to_ascii_radix_tb.sv */
module integer_to_ascii_radix_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;

	typedef struct {
		logic [itc_pkg::NUM_W-1:0] num;
		logic [itc_pkg::SEL_W-1:0] radix;
	} num_item_t;

	typedef struct {
		logic [itc_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} text_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic              m_tlast;

	num_item_t  pending_nums[$];
	text_beat_t expected_text[$];
	int         send_idle = 0;
	int         recv_idle = 0;
	int         errors = 0;
	int         cycles = 0;
	logic       hold_req = 1'b0;
	logic       hold_done = 1'b0;
	int         hold_left = 0;

	integer_to_ascii_radix u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [itc_pkg::CHAR_W-1:0] ascii_digit(input logic [31:0] d);
		if (d < 10)
			return itc_pkg::CHAR_W'(32'h30 + d);
		else
			return itc_pkg::CHAR_W'(32'h61 + d - 10);
	endfunction

	// queues the characters one number turns into
	function automatic void predict_text(input logic [itc_pkg::NUM_W-1:0] num,
					     input logic [itc_pkg::SEL_W-1:0] radix);
		logic [31:0] mag;
		logic [31:0] base;
		logic [31:0] digs [itc_pkg::CELLS];
		int          nd;
		text_beat_t  beat;
		mag = num;
		nd = 0;
		if (radix == itc_pkg::RADIX_OCT)
			base = 32'(itc_pkg::BASE_OCT);
		else if (radix == itc_pkg::RADIX_DEC)
			base = 32'(itc_pkg::BASE_DEC);
		else
			base = 32'(itc_pkg::BASE_HEX);
		if (radix == itc_pkg::RADIX_DEC && num[itc_pkg::NUM_W-1]) begin
			mag = 32'd0 - num;
			beat.ch = itc_pkg::MINUS_CHAR;
			beat.last = 1'b0;
			expected_text.push_back(beat);
		end
		do begin
			digs[nd] = mag % base;
			nd++;
			mag = mag / base;
		end while (mag != 0);
		for (int i = nd - 1; i >= 0; i--) begin
			beat.ch = ascii_digit(digs[i]);
			beat.last = (i == 0);
			expected_text.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		num_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_text(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (pending_nums.size() != 0 && $urandom_range(99) >= send_idle) begin
					nxt = pending_nums.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.num;
					s_tuser <= nxt.radix;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		text_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					$error("char_out: unexpected beat, actual %h", m_tdata);
					errors++;
				end else begin
					want = expected_text.pop_front();
					if (m_tdata !== {1'b0, want.ch}) begin
						$error("char_out: expected %h, actual %h", {1'b0, want.ch}, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("is_last: expected %b, actual %b", want.last, m_tlast);
						errors++;
					end
				end
			end
			// long stall so the block fills up and pushes back on its input
			if (hold_req && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_num(input logic [itc_pkg::NUM_W-1:0] num,
			       input logic [itc_pkg::SEL_W-1:0] radix);
		num_item_t it;
		it.num = num;
		it.radix = radix;
		pending_nums.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_nums.size() != 0 || s_tvalid || expected_text.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int s_idle, input int r_idle, input int count);
		logic [itc_pkg::NUM_W-1:0] num;
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < count; i++) begin
			num = $urandom() >> $urandom_range(31);
			if ($urandom_range(3) == 0)
				num = -num;
			else if ($urandom_range(7) == 0)
				num = $urandom();
			add_num(num, itc_pkg::SEL_W'($urandom_range(3)));
		end
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 29;
		recv_idle = 81;
		hold_req = 1'b1;
		for (int r = 0; r < 4; r++) begin
			add_num(32'h0000_0000, itc_pkg::SEL_W'(r));
			add_num(32'hffff_ffff, itc_pkg::SEL_W'(r));
		end
		add_num(32'h8000_0000, itc_pkg::RADIX_OCT);
		add_num(32'h8000_0000, itc_pkg::RADIX_DEC);
		add_num(32'h8000_0000, itc_pkg::RADIX_HEX);
		add_num(32'h7fff_ffff, itc_pkg::RADIX_OCT);
		add_num(32'h7fff_ffff, itc_pkg::RADIX_DEC);
		add_num(32'h7fff_ffff, itc_pkg::RADIX_HEX);
		add_num(32'd1, itc_pkg::RADIX_DEC);
		add_num(32'd7, itc_pkg::RADIX_OCT);
		add_num(32'd8, itc_pkg::RADIX_OCT);
		add_num(32'd10, itc_pkg::RADIX_HEX);
		add_num(32'd255, itc_pkg::RADIX_HEX);
		add_num(32'habcd_ef01, itc_pkg::RADIX_HEX);
		add_num(-32'sd123, itc_pkg::RADIX_DEC);
		add_num(32'd1000000000, itc_pkg::RADIX_DEC);
		wait_drained();
		run_phase(29, 81, 60);
		// sender slow, receiver mostly ready
		run_phase(81, 29, 60);
		run_phase(0, 0, 60);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
